// ===== rtl/cpdr_pkg.sv =====
// shared constants and types for the camera pixel decimate and rotate block
package cpdr_pkg;

    localparam int SRC_WIDTH   = 320;
    localparam int SRC_HEIGHT  = 240;
    localparam int HALF_HEIGHT = SRC_HEIGHT / 2;

    localparam int BYTE_W = 8;
    localparam int PIX_W  = 16;
    localparam int ADDR_W = 15;
    localparam int COL_W  = $clog2(SRC_WIDTH);
    localparam int ROW_W  = $clog2(SRC_HEIGHT);

    localparam logic PHASE_HIGH = 1'b0;
    localparam logic PHASE_LOW  = 1'b1;

    // decoded view of the byte being taken, handed to the output stage
    typedef struct packed {
        logic             low_byte;
        logic             keep;
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } pix_info_t;

endpackage

// ===== rtl/cpdr_in_if.sv =====
// camera byte stream channel
interface cpdr_in_if;
    logic                         valid;
    logic                         ready;
    logic [cpdr_pkg::BYTE_W-1:0]  data_byte;
    logic                         frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== rtl/cpdr_out_if.sv =====
// rotated pixel write channel
interface cpdr_out_if;
    logic                         valid;
    logic                         ready;
    logic [cpdr_pkg::ADDR_W-1:0]  write_address;
    logic [cpdr_pkg::PIX_W-1:0]   pixel;

    modport source (output valid, output write_address, output pixel, input ready);
    modport sink   (input valid, input write_address, input pixel, output ready);
endinterface

// ===== rtl/cpdr_position.sv =====
// byte phase, held high byte and source column/row counters
module cpdr_position (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [cpdr_pkg::BYTE_W-1:0] data_byte,
    input  logic                        frame_start,
    output cpdr_pkg::pix_info_t         info
);

    logic                        phase_reg, phase_next;
    logic [cpdr_pkg::BYTE_W-1:0] held_reg, held_next;
    logic [cpdr_pkg::COL_W-1:0]  col_reg, col_next;
    logic [cpdr_pkg::ROW_W-1:0]  row_reg, row_next;

    logic                        phase_eff;
    logic [cpdr_pkg::COL_W-1:0]  col_eff;
    logic [cpdr_pkg::ROW_W-1:0]  row_eff;

    // frame start restarts position before the byte is used
    assign phase_eff = frame_start ? cpdr_pkg::PHASE_HIGH : phase_reg;
    assign col_eff   = frame_start ? '0 : col_reg;
    assign row_eff   = frame_start ? '0 : row_reg;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (accept)
        begin
            col_next = col_eff;
            row_next = row_eff;
            if (phase_eff == cpdr_pkg::PHASE_HIGH)
            begin
                held_next  = data_byte;
                phase_next = cpdr_pkg::PHASE_LOW;
            end
            else
            begin
                phase_next = cpdr_pkg::PHASE_HIGH;
                if (col_eff == cpdr_pkg::COL_W'(cpdr_pkg::SRC_WIDTH - 1))
                begin
                    col_next = '0;
                    if (row_eff == cpdr_pkg::ROW_W'(cpdr_pkg::SRC_HEIGHT - 1))
                    begin
                        row_next = '0;
                    end
                    else
                    begin
                        row_next = row_eff + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_eff + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        info.low_byte = (phase_eff == cpdr_pkg::PHASE_LOW);
        info.keep     = info.low_byte && !row_eff[0] && !col_eff[0];
        info.pixel    = {held_reg, data_byte};
        info.column   = col_eff;
        info.row      = row_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= cpdr_pkg::PHASE_HIGH;
            held_reg  <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

endmodule

// ===== rtl/cpdr_out_stage.sv =====
// rotated address computation and output register
module cpdr_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  cpdr_pkg::pix_info_t info,
    output logic                in_ready,
    cpdr_out_if.source          out
);

    logic                        valid_reg, valid_next;
    logic [cpdr_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [cpdr_pkg::PIX_W-1:0]  pixel_reg, pixel_next;

    logic [cpdr_pkg::ADDR_W-1:0] col_half, row_half, addr_calc;

    // column/2 * half height + (half height - 1 - row/2), kept to 15 bits
    assign col_half  = cpdr_pkg::ADDR_W'(info.column >> 1);
    assign row_half  = cpdr_pkg::ADDR_W'(info.row >> 1);
    assign addr_calc = col_half * cpdr_pkg::ADDR_W'(cpdr_pkg::HALF_HEIGHT)
                     + cpdr_pkg::ADDR_W'(cpdr_pkg::HALF_HEIGHT - 1) - row_half;

    assign in_ready = !valid_reg || out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        pixel_next = pixel_reg;
        if (out.ready)
        begin
            valid_next = 1'b0;
        end
        if (accept && info.keep)
        begin
            valid_next = 1'b1;
            addr_next  = addr_calc;
            pixel_next = info.pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        pixel_reg <= pixel_next;
    end

    assign out.valid         = valid_reg;
    assign out.write_address = addr_reg;
    assign out.pixel         = pixel_reg;

endmodule

// ===== rtl/camera_pixel_decimate_rotate_unit.sv =====
// top level of the camera pixel decimate and rotate block
// takes one camera byte per cycle (two bytes per RGB565 pixel, high byte
// first) and keeps only pixels on even rows and even columns, halving the
// source frame in each dimension; each kept pixel leaves on the output
// channel with its word address in a frame buffer rotated by 90 degrees,
// column/2 * half height + (half height - 1 - row/2), cut to 15 bits.
// frame_start on a byte restarts the byte phase and counters, and that byte
// is the high byte of pixel (0, 0). one transaction per cycle is sustained on
// the input; a result appears in the cycle after the transaction carrying its
// low byte, from a single output register. the input stalls only while that
// register is full and the output side does not take it.
module camera_pixel_decimate_rotate_unit (
    input  logic      clk,
    input  logic      rst_n,
    cpdr_in_if.sink   in,
    cpdr_out_if.source out
);

    cpdr_pkg::pix_info_t info;
    logic                in_ready;
    logic                accept;

    // input transaction completes
    assign in.ready = in_ready;
    assign accept   = in.valid && in_ready;

    // byte pairing and source position
    cpdr_position u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (in.data_byte),
        .frame_start (in.frame_start),
        .info        (info)
    );

    // address generation and output register
    cpdr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .info     (info),
        .in_ready (in_ready),
        .out      (out)
    );

    // a kept pixel always shows up on the output next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && info.keep |=> out.valid)
        else $error("kept pixel did not reach output register");

    // input only stalls behind a full, unaccepted output register
    assert property (@(posedge clk) disable iff (!rst_n)
        !in.ready |-> out.valid && !out.ready)
        else $error("input stalled without output back-pressure");

    // only a low byte can complete a kept pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        info.keep |-> info.low_byte)
        else $error("pixel kept on a high byte");

    // a high byte never produces a new result
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !info.low_byte && out.valid && out.ready |=> !out.valid)
        else $error("result produced from a high byte");

endmodule

// ===== sim/cpdr_checker.sv =====
// checker that predicts and compares the rotated pixel writes of the decimate and rotate block
`timescale 1ns / 1ps

module cpdr_checker (
    input  logic clk,
    input  logic rst_n,
    cpdr_in_if   cam_ch,
    cpdr_out_if  pix_ch,
    output int   fail_count,
    output int   pending_results
);

    typedef struct packed {
        logic [cpdr_pkg::ADDR_W-1:0] write_address;
        logic [cpdr_pkg::PIX_W-1:0]  pixel;
    } rotated_pixel_t;

    // predictor state
    logic                        cur_phase;
    logic [cpdr_pkg::BYTE_W-1:0] upper_byte;
    logic [cpdr_pkg::COL_W-1:0]  src_col;
    logic [cpdr_pkg::ROW_W-1:0]  src_row;

    rotated_pixel_t pending_pixels[$];

    initial begin
        fail_count      = 0;
        pending_results = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns checker: %s", $time, what);
        fail_count++;
    endtask

    // takes one camera byte, returns 1 when it yields a kept pixel
    function automatic logic decimate_byte(input logic [cpdr_pkg::BYTE_W-1:0] b,
                                           input logic fs,
                                           output rotated_pixel_t res);
        int unsigned addr;
        logic        keep;
        res  = '0;
        keep = 1'b0;
        if (fs)
        begin
            cur_phase = cpdr_pkg::PHASE_HIGH;
            src_col   = '0;
            src_row   = '0;
        end
        if (cur_phase == cpdr_pkg::PHASE_HIGH)
        begin
            upper_byte = b;
            cur_phase  = cpdr_pkg::PHASE_LOW;
        end
        else
        begin
            cur_phase = cpdr_pkg::PHASE_HIGH;
            keep      = !src_row[0] && !src_col[0];
            addr      = (int'(src_col) >> 1) * cpdr_pkg::HALF_HEIGHT
                        + cpdr_pkg::HALF_HEIGHT - 1 - (int'(src_row) >> 1);
            res.write_address = addr[cpdr_pkg::ADDR_W-1:0];
            res.pixel         = {upper_byte, b};
            // column wraps at end of line, row wraps at end of frame
            if (int'(src_col) + 1 >= cpdr_pkg::SRC_WIDTH)
            begin
                src_col = '0;
                if (int'(src_row) + 1 >= cpdr_pkg::SRC_HEIGHT)
                    src_row = '0;
                else
                    src_row = src_row + 1'b1;
            end
            else
                src_col = src_col + 1'b1;
        end
        return keep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rotated_pixel_t want;
        rotated_pixel_t fresh;
        if (!rst_n)
        begin
            cur_phase  = cpdr_pkg::PHASE_HIGH;
            upper_byte = '0;
            src_col    = '0;
            src_row    = '0;
            pending_pixels.delete();
        end
        else
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                if (pending_pixels.size() == 0)
                    report_mismatch($sformatf("unexpected write addr %0d pixel %04h",
                                              pix_ch.write_address, pix_ch.pixel));
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pix_ch.write_address !== want.write_address)
                        report_mismatch($sformatf("write_address %0d, predicted %0d",
                                                  pix_ch.write_address, want.write_address));
                    if (pix_ch.pixel !== want.pixel)
                        report_mismatch($sformatf("pixel %04h, predicted %04h",
                                                  pix_ch.pixel, want.pixel));
                end
            end
            if (cam_ch.valid && cam_ch.ready)
            begin
                if (decimate_byte(cam_ch.data_byte, cam_ch.frame_start, fresh))
                    pending_pixels.push_back(fresh);
            end
        end
        pending_results = pending_pixels.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// top of the testbench for the camera pixel decimate and rotate block
`timescale 1ns / 1ps

module tb_top;

    logic clk;
    logic rst_n;

    int fail_count;
    int pending_results;

    // pacing controls for the sender and the receiver
    bit tx_steady;      // sender offers a byte every cycle
    bit rx_steady;      // receiver draws no random stall
    int hold_off_len;   // one-shot long receiver stall, in cycles
    int sent_count;

    cpdr_in_if  cam_ch ();
    cpdr_out_if pix_ch ();

    camera_pixel_decimate_rotate_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (cam_ch),
        .out   (pix_ch)
    );

    cpdr_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cam_ch          (cam_ch),
        .pix_ch          (pix_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, well beyond the slowest legal run (about 1100 bytes, each
    // with the longest gaps and receiver stalls, plus the long hold-off)
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // one camera byte as one input transaction; a random gap before it
    // unless the sender is in a steady stretch
    task automatic send_byte(input logic [cpdr_pkg::BYTE_W-1:0] b, input logic fs);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            cam_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cam_ch.valid       <= 1'b1;
        cam_ch.data_byte   <= b;
        cam_ch.frame_start <= fs;
        @(posedge clk);
        while (!cam_ch.ready) @(posedge clk);
        @(negedge clk);
        sent_count++;
    endtask

    // a run of random bytes, optionally opened by frame_start, with stray
    // frame_start marks at about one in noise_odds bytes (0 = none)
    task automatic send_run(input int len, input bit with_start, input int noise_odds);
        bit fs;
        for (int i = 0; i < len; i++)
        begin
            fs = (i == 0 && with_start)
                 || (noise_odds > 0 && $urandom_range(1, noise_odds) == 1);
            send_byte(8'($urandom_range(0, 255)), fs);
        end
    endtask

    // sender goes quiet until every predicted pixel has been written out;
    // always waits on a falling edge before checking, so valid is driven once per step
    task automatic drain_results;
        cam_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0);
    endtask

    // receiver: draws a stall per transaction, or takes a requested long
    // hold-off counted here in cycles
    initial
    begin : receiver
        int stall;
        pix_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off_len > 0)
            begin
                stall        = hold_off_len;
                hold_off_len = 0;
            end
            else if (rx_steady)
                stall = 0;
            else
                stall = $urandom_range(0, 7);
            if (stall > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pix_ch.ready <= 1'b1;
            @(posedge clk);
            while (!pix_ch.valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        int target;
        int len;
        cam_ch.valid       = 1'b0;
        cam_ch.data_byte   = '0;
        cam_ch.frame_start = 1'b0;
        tx_steady          = 1'b0;
        rx_steady          = 1'b0;
        hold_off_len       = 0;
        sent_count         = 0;
        rst_n              = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        // pixel (0, 0) kept at the top of the rotated column, all-ones then all-zeros byte
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        // odd column dropped
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // column 2 kept, alternating bit patterns
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        // frame start mid pixel: held high byte discarded
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'hAA, 1'b0);
        // frame start on a byte already in high phase
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        // frame start on back to back bytes
        send_byte(8'hC3, 1'b1);
        send_byte(8'h3C, 1'b1);
        send_byte(8'h0F, 1'b0);
        drain_results();

        // back pressure: receiver holds off long while the sender streams,
        // so the output register fills and the input stalls
        hold_off_len = 64;
        tx_steady    = 1'b1;
        send_run(48, 1'b1, 0);
        tx_steady = 1'b0;
        drain_results();

        // the whole first line at full rate plus a few pixels of the second,
        // covering the highest address, the line end and an odd row
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        send_run(2 * cpdr_pkg::SRC_WIDTH + 8, 1'b1, 0);
        drain_results();

        // random part: mostly frame-started runs of random pixels, with
        // stray frame starts and varied pacing
        target = sent_count + 400;
        while (sent_count < target)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                              : $urandom_range(1, 60);
            send_run(len, $urandom_range(0, 5) != 0, 40);
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // wait for the last writes, then give any stray write time to show
        drain_results();
        repeat (16) @(negedge clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cpdr_pkg.sv
rtl/cpdr_in_if.sv
rtl/cpdr_out_if.sv
rtl/cpdr_position.sv
rtl/cpdr_out_stage.sv
rtl/camera_pixel_decimate_rotate_unit.sv
sim/cpdr_checker.sv
sim/tb_top.sv
